// ----- rtl/gaf_pkg.sv -----
// ----------------------------------------------------------------------------
// gaf_pkg
// shared widths, defaults and sequencer states of the recurrence pair engine
// ----------------------------------------------------------------------------
package gaf_pkg;

    localparam int SAMPLE_W      = 16;
    localparam int LAG_W         = 6;
    localparam int GAF_W         = 16;
    localparam int DIST_W        = 16;
    localparam int OUT_FRAC      = 14;
    localparam int GAF_MAX       = 16384;

    localparam int WINDOW_DEF    = 64;
    localparam int FRAC_BITS_DEF = 12;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_ROOT,
        ST_WRITE,
        ST_PAIR,
        ST_DRAIN
    } gaf_state_t;

endpackage

// ----- rtl/gaf_recurrence_pair_engine.sv -----
// ----------------------------------------------------------------------------
// gaf_recurrence_pair_engine
// angular summation field and recurrence distance for every pair formed by a
// new sample and the samples held in the history window
// ----------------------------------------------------------------------------
//  channel | signals                          | handshake
//  --------+----------------------------------+-------------------------------
//  in      | sample                           | in_valid / in_stall
//  out     | lag, gaf_value,                  | out_valid / out_stall
//          | recurrence_distance, last_of_run |
//
//  each sample steps through the accepting idle state, the squaring state, the
//  bit-serial square root, one history write, then one pair per cycle from the
//  single history read port while out_stall does not hold the pipeline, and
//  last a drain of the read and product stages
//  rst_n clears the sequencer, pointers, fill count and stage valid bits;
//  the history memory needs no clearing since only filled slots are read
//  out_stall freezes the whole pair pipeline; in_stall is high while busy
// ----------------------------------------------------------------------------
module gaf_recurrence_pair_engine #(
    parameter int WINDOW        = gaf_pkg::WINDOW_DEF,
    parameter int FRACTION_BITS = gaf_pkg::FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [gaf_pkg::SAMPLE_W-1:0] sample,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic        [gaf_pkg::LAG_W-1:0]    lag,
    output logic signed [gaf_pkg::GAF_W-1:0]    gaf_value,
    output logic        [gaf_pkg::DIST_W-1:0]   recurrence_distance,
    output logic                                last_of_run
);

    import gaf_pkg::*;

    localparam int AW  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CW  = $clog2(WINDOW + 1);
    localparam int CHW = FRACTION_BITS + 2;
    localparam int SNW = FRACTION_BITS + 1;
    localparam int RW  = 2 * FRACTION_BITS + 1;
    localparam int CCW = 2 * CHW;
    localparam int SSW = 2 * SNW;
    localparam int PW  = 2 * FRACTION_BITS + 5;
    localparam int SH  = 2 * FRACTION_BITS - OUT_FRAC;
    localparam int QW  = PW - SH;
    localparam int XW  = SAMPLE_W + 1;

    localparam logic signed [XW-1:0] ONE_X     = XW'(1 << FRACTION_BITS);
    localparam logic signed [XW-1:0] NEG_ONE_X = -ONE_X;
    localparam logic [RW-1:0]        ONE_SQ    = RW'(1) << (2 * FRACTION_BITS);
    localparam logic [PW-1:0]        RND_BIAS  = PW'(1) << (SH - 1);
    localparam logic signed [QW-1:0] Q_MAX     = QW'(GAF_MAX);
    localparam logic signed [QW-1:0] Q_MIN     = QW'(-GAF_MAX);
    localparam logic [AW-1:0]        LAST_SLOT = AW'(WINDOW - 1);
    localparam logic [CW-1:0]        FULL      = CW'(WINDOW);

    gaf_state_t state_reg, state_next;

    logic signed [SAMPLE_W-1:0] mem_raw [WINDOW];
    logic signed [CHW-1:0]      mem_cos [WINDOW];
    logic        [SNW-1:0]      mem_sin [WINDOW];

    logic signed [SAMPLE_W-1:0] x_reg;
    logic signed [CHW-1:0]      c_reg;
    logic        [SNW-1:0]      s_reg;
    logic        [RW-1:0]       v_reg;
    logic        [RW-1:0]       res_reg;
    logic        [RW-1:0]       bit_reg;
    logic        [AW-1:0]       wptr_reg;
    logic        [AW-1:0]       rptr_reg;
    logic        [AW-1:0]       k_reg;
    logic        [CW-1:0]       fill_reg;

    logic                       b_valid_reg;
    logic signed [SAMPLE_W-1:0] b_raw_reg;
    logic signed [CHW-1:0]      b_cos_reg;
    logic        [SNW-1:0]      b_sin_reg;
    logic        [AW-1:0]       b_lag_reg;
    logic                       b_last_reg;

    logic                       c_valid_reg;
    logic signed [CCW-1:0]      c_cc_reg;
    logic        [SSW-1:0]      c_ss_reg;
    logic signed [XW-1:0]       c_diff_reg;
    logic        [AW-1:0]       c_lag_reg;
    logic                       c_last_reg;

    logic                       out_valid_reg;
    logic        [LAG_W-1:0]    lag_reg;
    logic signed [GAF_W-1:0]    gaf_reg;
    logic        [DIST_W-1:0]   dist_reg;
    logic                       last_reg;

    logic                       accept;
    logic                       adv;
    logic                       issue;
    logic                       issue_last;
    logic signed [XW-1:0]       x_ext;
    logic signed [XW-1:0]       x_clamp;
    logic signed [CCW-1:0]      c_sq;
    logic        [RW:0]         trial;
    logic signed [PW-1:0]       p_sum;
    logic signed [QW-1:0]       q_val;
    logic signed [XW-1:0]       d_abs;

    assign accept     = in_valid && !in_stall;
    assign adv        = !out_valid_reg || !out_stall;
    assign issue      = (state_reg == ST_PAIR) && adv;
    assign issue_last = (CW'(k_reg) + CW'(1)) == fill_reg;

    assign x_ext   = XW'(sample);
    assign x_clamp = (x_ext > ONE_X) ? ONE_X : ((x_ext < NEG_ONE_X) ? NEG_ONE_X : x_ext);
    assign c_sq    = c_reg * c_reg;
    assign trial   = (RW + 1)'(res_reg) + (RW + 1)'(bit_reg);

    assign p_sum = PW'(c_cc_reg) - PW'(c_ss_reg) + RND_BIAS;
    assign q_val = QW'(p_sum >>> SH);
    assign d_abs = c_diff_reg[XW-1] ? -c_diff_reg : c_diff_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_stall   = (state_reg != ST_IDLE);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_SQUARE;
                end
            end
            ST_SQUARE:
            begin
                state_next = ST_ROOT;
            end
            ST_ROOT:
            begin
                if (bit_reg[0])
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                state_next = ST_PAIR;
            end
            ST_PAIR:
            begin
                if (adv && issue_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!b_valid_reg && !c_valid_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // sample capture, squaring and bit-serial square root
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            x_reg <= sample;
            c_reg <= CHW'(x_clamp);
        end
        if (state_reg == ST_SQUARE)
        begin
            v_reg   <= ONE_SQ - RW'(c_sq);
            res_reg <= '0;
            bit_reg <= ONE_SQ;
        end
        else if (state_reg == ST_ROOT)
        begin
            if ((RW + 1)'(v_reg) >= trial)
            begin
                v_reg   <= v_reg - RW'(trial);
                res_reg <= (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_reg <= res_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
        if (state_reg == ST_WRITE)
        begin
            s_reg <= SNW'(res_reg);
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            k_reg    <= '0;
            fill_reg <= '0;
        end
        else if (state_reg == ST_WRITE)
        begin
            rptr_reg <= wptr_reg;
            k_reg    <= '0;
            wptr_reg <= (wptr_reg == LAST_SLOT) ? '0 : wptr_reg + AW'(1);
            if (fill_reg != FULL)
            begin
                fill_reg <= fill_reg + CW'(1);
            end
        end
        else if (issue)
        begin
            rptr_reg <= (rptr_reg == '0) ? LAST_SLOT : rptr_reg - AW'(1);
            k_reg    <= k_reg + AW'(1);
        end
    end

    // history memory, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_WRITE)
        begin
            mem_raw[wptr_reg] <= x_reg;
            mem_cos[wptr_reg] <= c_reg;
            mem_sin[wptr_reg] <= SNW'(res_reg);
        end
        if (issue)
        begin
            b_raw_reg  <= mem_raw[rptr_reg];
            b_cos_reg  <= mem_cos[rptr_reg];
            b_sin_reg  <= mem_sin[rptr_reg];
            b_lag_reg  <= k_reg;
            b_last_reg <= issue_last;
        end
    end

    // pair pipeline: read data, products, rounded output
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            b_valid_reg   <= (state_reg == ST_PAIR);
            c_valid_reg   <= b_valid_reg;
            out_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c_cc_reg   <= c_reg * b_cos_reg;
            c_ss_reg   <= s_reg * b_sin_reg;
            c_diff_reg <= XW'(x_reg) - XW'(b_raw_reg);
            c_lag_reg  <= b_lag_reg;
            c_last_reg <= b_last_reg;

            lag_reg  <= LAG_W'(c_lag_reg);
            dist_reg <= DIST_W'(d_abs);
            last_reg <= c_last_reg;
            if (q_val > Q_MAX)
            begin
                gaf_reg <= GAF_W'(Q_MAX);
            end
            else if (q_val < Q_MIN)
            begin
                gaf_reg <= GAF_W'(Q_MIN);
            end
            else
            begin
                gaf_reg <= GAF_W'(q_val);
            end
        end
    end

    assign out_valid           = out_valid_reg;
    assign lag                 = lag_reg;
    assign gaf_value           = gaf_reg;
    assign recurrence_distance = dist_reg;
    assign last_of_run         = last_reg;

`ifndef SYNTHESIS
    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (!b_valid_reg && !c_valid_reg))
        else $error("pair pipeline busy while taking a new sample");

    a_issue_in_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PAIR) |-> (CW'(k_reg) < fill_reg))
        else $error("pair issued beyond the filled history");

    a_accept_start: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_SQUARE))
        else $error("accepted sample did not start the sequence");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg <= FULL))
        else $error("fill count beyond window");
`endif

endmodule

// ----- sim/tb_gaf_recurrence_pair_engine.sv -----
// ----------------------------------------------------------------------------
// tb_gaf_recurrence_pair_engine
// self-checking bench for the recurrence pair engine: a shadow copy of the
// sample history predicts every pair transaction, and each accepted output is
// compared with the oldest pending pair while both channels idle at random
// ----------------------------------------------------------------------------
module tb_gaf_recurrence_pair_engine;

    timeunit 1ns;
    timeprecision 1ps;

    import gaf_pkg::*;

    localparam int HIST     = WINDOW_DEF;
    localparam int ONE_FX   = 1 << FRAC_BITS_DEF;
    localparam int SHIFT_Q  = 2 * FRAC_BITS_DEF - OUT_FRAC;
    localparam int N_RANDOM = 300;

    typedef struct {
        bit        [LAG_W-1:0]  lag;
        bit signed [GAF_W-1:0]  gaf;
        bit        [DIST_W-1:0] distance;
        bit                     last;
    } pair_result_t;

    class pair_field_model;
        bit signed [SAMPLE_W-1:0] raw_hist [HIST];
        bit signed [13:0]         cos_hist [HIST];
        bit        [12:0]         sin_hist [HIST];
        bit        [LAG_W-1:0]    wr_ptr;
        int                       fill;
        pair_result_t             pending_pairs [$];
        int                       mismatches;

        function new();
            foreach (raw_hist[i])
            begin
                raw_hist[i] = '0;
                cos_hist[i] = '0;
                sin_hist[i] = '0;
            end
            wr_ptr     = '0;
            fill       = 0;
            mismatches = 0;
        endfunction

        function automatic bit [12:0] floor_root(int v);
            bit [12:0] r;
            bit [12:0] t;
            r = '0;
            for (int b = 12; b >= 0; b--)
            begin
                t = r | (13'd1 << b);
                if (int'(t) * int'(t) <= v)
                    r = t;
            end
            return r;
        endfunction

        function void note_sample(bit signed [SAMPLE_W-1:0] x);
            int           c;
            int           s;
            int           d;
            longint       p;
            longint       g;
            bit [LAG_W-1:0] slot;
            bit [LAG_W-1:0] j;
            pair_result_t r;
            c = int'(x);
            if (c > ONE_FX)
                c = ONE_FX;
            if (c < -ONE_FX)
                c = -ONE_FX;
            s = int'(floor_root(ONE_FX * ONE_FX - c * c));
            slot = wr_ptr;
            raw_hist[slot] = x;
            cos_hist[slot] = 14'(c);
            sin_hist[slot] = 13'(s);
            wr_ptr = wr_ptr + 1'b1;
            if (fill < HIST)
                fill++;
            for (int k = 0; k < fill; k++)
            begin
                j = slot - k[LAG_W-1:0];
                p = longint'(c) * longint'(cos_hist[j])
                    - longint'(s) * longint'(sin_hist[j]);
                g = (p + (longint'(1) << (SHIFT_Q - 1))) >>> SHIFT_Q;
                if (g > GAF_MAX)
                    g = GAF_MAX;
                if (g < -GAF_MAX)
                    g = -GAF_MAX;
                d = int'(x) - int'(raw_hist[j]);
                if (d < 0)
                    d = -d;
                r.lag      = k[LAG_W-1:0];
                r.gaf      = g[GAF_W-1:0];
                r.distance = d[DIST_W-1:0];
                r.last     = (k + 1 == fill);
                pending_pairs.push_back(r);
            end
        endfunction

        function void check_pair(bit [LAG_W-1:0] lag, bit signed [GAF_W-1:0] gaf,
                                 bit [DIST_W-1:0] distance, bit last);
            pair_result_t e;
            if (pending_pairs.size() == 0)
            begin
                $error("unexpected transaction: lag %0d gaf_value %0d", lag, gaf);
                mismatches++;
                return;
            end
            e = pending_pairs.pop_front();
            if (lag != e.lag)
            begin
                $error("lag: expected %0d, actual %0d", e.lag, lag);
                mismatches++;
            end
            if (gaf != e.gaf)
            begin
                $error("gaf_value: expected %0d, actual %0d", e.gaf, gaf);
                mismatches++;
            end
            if (distance != e.distance)
            begin
                $error("recurrence_distance: expected %0d, actual %0d", e.distance, distance);
                mismatches++;
            end
            if (last != e.last)
            begin
                $error("last_of_run: expected %0d, actual %0d", e.last, last);
                mismatches++;
            end
        endfunction
    endclass

    logic                       clk;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_stall;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       out_valid;
    logic                       out_stall;
    logic        [LAG_W-1:0]    lag;
    logic signed [GAF_W-1:0]    gaf_value;
    logic        [DIST_W-1:0]   recurrence_distance;
    logic                       last_of_run;

    pair_field_model pairs = new();
    int              n_sent = 0;

    gaf_recurrence_pair_engine i_dut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .in_valid            (in_valid),
        .in_stall            (in_stall),
        .sample              (sample),
        .out_valid           (out_valid),
        .out_stall           (out_stall),
        .lag                 (lag),
        .gaf_value           (gaf_value),
        .recurrence_distance (recurrence_distance),
        .last_of_run         (last_of_run)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    task automatic send_sample(bit signed [SAMPLE_W-1:0] v);
        int gap;
        gap = (n_sent % 60 < 12) ? 0 : $urandom_range(0, 13);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        sample   <= v;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pairs.note_sample(v);
        n_sent++;
        @(negedge clk);
    endtask

    function automatic bit signed [SAMPLE_W-1:0] pick_sample();
        int mode;
        mode = $urandom_range(0, 9);
        if (mode < 6)
            return SAMPLE_W'($urandom_range(0, 2 * ONE_FX) - ONE_FX);
        else if (mode < 7)
            return SAMPLE_W'($urandom_range(0, 4) - 2
                             + (($urandom_range(0, 1) != 0) ? ONE_FX : -ONE_FX));
        else
            return SAMPLE_W'($urandom());
    endfunction

    initial
    begin
        bit signed [SAMPLE_W-1:0] directed [$];
        directed = '{16'sd0, 16'sd32767, -16'sd32768, 16'sd4096, -16'sd4096,
                     16'sd4097, -16'sd4097, 16'sd1, -16'sd1, 16'sd2048, -16'sd2048,
                     16'sh5555, 16'shAAAA, 16'sd4095, -16'sd4095, 16'sd2896,
                     -16'sd2896, 16'sd8192, -16'sd8192, 16'sd0, 16'sd4096};
        rst_n    = 1'b0;
        in_valid = 1'b0;
        sample   = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        foreach (directed[i])
            send_sample(directed[i]);
        repeat (N_RANDOM)
            send_sample(pick_sample());
        in_valid <= 1'b0;
        while (pairs.pending_pairs.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (pairs.mismatches == 0 && pairs.pending_pairs.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // output side back-pressure, quiet stretches every few hundred transactions
    initial
    begin
        int hold;
        int n_seen;
        n_seen    = 0;
        out_stall = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            hold = (n_seen % 256 < 64) ? 0 : $urandom_range(0, 13);
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(negedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!(out_valid && !out_stall))
                @(posedge clk);
            n_seen++;
            @(negedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            pairs.check_pair(lag, gaf_value, recurrence_distance, last_of_run);
    end

    initial
    begin
        #4_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
